/* src/ncc_pkg.sv */
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants for the n-chance clock page replacer.
// ----------------------------------------------------------------------------
package ncc_pkg;

  // default sizing of the working-set table
  localparam int SET_DEPTH_DEF        = 16;
  localparam int PAGE_NUMBER_BITS_DEF = 20;

  // fixed port field widths
  localparam int PAGE_W        = 20;
  localparam int SLOT_W        = 4;
  localparam int SET_SIZE_W    = 5;
  localparam int SWEEP_LIMIT_W = 8;
  localparam int CFG_DATA_W    = 8;
  localparam int SWEEP_W       = 8;

  // configuration reset values
  localparam logic [SET_SIZE_W-1:0]    SET_SIZE_RST    = 5'd16;
  localparam logic [SWEEP_LIMIT_W-1:0] SWEEP_LIMIT_RST = 8'd1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SET_SIZE    = 1'b0,
    CFG_SWEEP_LIMIT = 1'b1
  } cfg_idx_t;

  // result codes
  typedef enum logic [1:0] {
    OC_NOTED    = 2'd0,
    OC_PLACED   = 2'd1,
    OC_REPLACED = 2'd2,
    OC_IGNORED  = 2'd3
  } outcome_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_EVAL  = 2'd2,
    ST_SHORT = 2'd3
  } ctrl_state_t;

  // per-entry bookkeeping kept next to the page number in the table
  typedef struct packed {
    logic [SWEEP_W-1:0] sweeps;
    logic               used;
    logic               modified;
  } entry_meta_t;

  localparam int META_W = SWEEP_W + 2;

  // one result beat from the controller to the output register
  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] victim_page;
    logic              victim_dirty;
  } result_t;

endpackage

/* src/ncc_entry_ram.sv */
// ----------------------------------------------------------------------------
// ncc_entry_ram
// Working-set table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ncc_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 30
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ncc_sweep_ctrl.sv */
// ----------------------------------------------------------------------------
// ncc_sweep_ctrl
// Fill count, clock hand and the read-modify-write sequencer over the table.
// ----------------------------------------------------------------------------
module ncc_sweep_ctrl import ncc_pkg::*; #(
  parameter int SET_DEPTH        = SET_DEPTH_DEF,
  parameter int PAGE_NUMBER_BITS = PAGE_NUMBER_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input beat
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_command,
  input  logic [PAGE_W-1:0]                          in_page,
  input  logic [SLOT_W-1:0]                          in_slot,
  input  logic                                       in_is_write,
  // configuration
  input  logic [SET_SIZE_W-1:0]                      set_size,
  input  logic [SWEEP_LIMIT_W-1:0]                   sweep_limit,
  // table port
  output logic                                       mem_rd_en,
  output logic [$clog2(SET_DEPTH)-1:0]               mem_rd_addr,
  input  logic [PAGE_NUMBER_BITS+META_W-1:0]         mem_rd_data,
  output logic                                       mem_wr_en,
  output logic [$clog2(SET_DEPTH)-1:0]               mem_wr_addr,
  output logic [PAGE_NUMBER_BITS+META_W-1:0]         mem_wr_data,
  // result beat
  output logic                                       res_valid,
  input  logic                                       res_ready,
  output result_t                                    res
);

  localparam int IW = $clog2(SET_DEPTH);
  localparam int CW = $clog2(SET_DEPTH + 1);
  localparam int PB = PAGE_NUMBER_BITS;

  ctrl_state_t      state_r, state_nxt;
  logic [CW-1:0]    fill_r;
  logic [IW-1:0]    hand_r;
  logic [IW-1:0]    cur_r;
  logic             cmd_r;
  logic [PB-1:0]    page_r;
  logic [SLOT_W-1:0] slot_r;
  logic             write_r;

  logic [31:0]      size_ext, eff_size, fill_ext, slot_ext, hand_ext, nx_ext, cur_ext;
  logic [31:0]      fill_slot_ext;
  logic [63:0]      page_ext, rd_page_ext;
  logic             room, slot_ok;
  logic [IW-1:0]    slot_idx, hand_start, nxt_idx, fill_idx;
  logic [PB-1:0]    rd_page;
  entry_meta_t      rd_meta;
  logic             neg;
  logic [8:0]       limit, lim;
  logic [SWEEP_W-1:0] sweeps_inc;
  logic             victim;

  // effective table size: zero acts as one, large values saturate
  assign size_ext = 32'(set_size);
  assign eff_size = (size_ext == 32'd0) ? 32'd1 :
                    (size_ext > 32'(SET_DEPTH)) ? 32'(SET_DEPTH) : size_ext;
  assign fill_ext = 32'(fill_r);
  assign room     = fill_ext < eff_size;

  // access slot check and index
  assign slot_ext = 32'(in_slot);
  assign slot_ok  = slot_ext < fill_ext;
  assign slot_idx = slot_ext[IW-1:0];

  // sweep start: a hand past the filled part restarts at slot 0
  assign hand_ext   = 32'(hand_r);
  assign hand_start = (hand_ext >= fill_ext) ? '0 : hand_r;

  // next slot after the current one, wrapping at the fill count
  assign cur_ext = 32'(cur_r);
  assign nx_ext  = cur_ext + 32'd1;
  assign nxt_idx = (nx_ext >= fill_ext) ? '0 : nx_ext[IW-1:0];

  assign fill_idx      = fill_ext[IW-1:0];
  assign fill_slot_ext = fill_ext;

  assign page_ext = 64'(in_page);

  // split the table word
  assign rd_meta     = entry_meta_t'(mem_rd_data[META_W-1:0]);
  assign rd_page     = mem_rd_data[PB+META_W-1:META_W];
  assign rd_page_ext = 64'(rd_page);

  // sweep limit, one more for modified pages when the setting is negative
  assign neg        = sweep_limit[SWEEP_LIMIT_W-1];
  assign limit      = {1'b0, neg ? (~sweep_limit + 8'd1) : sweep_limit};
  assign lim        = limit + 9'(neg & rd_meta.modified);
  assign sweeps_inc = (rd_meta.sweeps == '1) ? rd_meta.sweeps : rd_meta.sweeps + 8'd1;
  assign victim     = {1'b0, sweeps_inc} >= lim;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command) begin
            state_nxt = slot_ok ? ST_READ : ST_SHORT;
          end else begin
            state_nxt = room ? ST_SHORT : ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (cmd_r) begin
          state_nxt = res_ready ? ST_IDLE : ST_EVAL;
        end else if (rd_meta.used || !victim) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = res_ready ? ST_IDLE : ST_EVAL;
        end
      end
      ST_SHORT: begin
        state_nxt = res_ready ? ST_IDLE : ST_SHORT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs: handshake, table access and result
  always_comb begin
    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cur_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_r;
    mem_wr_data = mem_rd_data;
    res_valid   = 1'b0;
    res         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        mem_rd_en = 1'b1;
      end
      ST_EVAL: begin
        if (cmd_r) begin
          // access: mark used, and modified on a write
          mem_wr_en   = res_ready;
          mem_wr_data = {rd_page, rd_meta.sweeps, 1'b1, rd_meta.modified | write_r};
          res_valid   = 1'b1;
          res.outcome = OC_NOTED;
          res.slot    = slot_r;
        end else if (rd_meta.used) begin
          // second chance: clear used and count
          mem_wr_en   = 1'b1;
          mem_wr_data = {rd_page, SWEEP_W'(0), 1'b0, rd_meta.modified};
        end else if (!victim) begin
          // not old enough yet: raise count
          mem_wr_en   = 1'b1;
          mem_wr_data = {rd_page, sweeps_inc, 1'b0, rd_meta.modified};
        end else begin
          // evict and install the new page as used
          mem_wr_en        = res_ready;
          mem_wr_data      = {page_r, SWEEP_W'(0), 1'b1, 1'b0};
          res_valid        = 1'b1;
          res.outcome      = OC_REPLACED;
          res.slot         = cur_ext[SLOT_W-1:0];
          res.victim_page  = rd_page_ext[PAGE_W-1:0];
          res.victim_dirty = rd_meta.modified;
        end
      end
      ST_SHORT: begin
        res_valid = 1'b1;
        if (cmd_r) begin
          res.outcome = OC_IGNORED;
          res.slot    = slot_r;
        end else begin
          // placement into the next free slot
          mem_wr_en   = res_ready;
          mem_wr_addr = fill_idx;
          mem_wr_data = {page_r, SWEEP_W'(0), 1'b0, 1'b0};
          res.outcome = OC_PLACED;
          res.slot    = fill_slot_ext[SLOT_W-1:0];
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // fill count and clock hand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hand_r <= '0;
    end else begin
      if (state_r == ST_SHORT && !cmd_r && res_ready) begin
        fill_r <= fill_r + CW'(1);
        hand_r <= '0;
      end else if (state_r == ST_EVAL && !cmd_r && !rd_meta.used && victim && res_ready) begin
        hand_r <= nxt_idx;
      end
    end
  end

  // item capture and sweep position
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r   <= in_command;
      page_r  <= page_ext[PB-1:0];
      slot_r  <= in_slot;
      write_r <= in_is_write;
      cur_r   <= in_command ? slot_idx : hand_start;
    end else if (state_r == ST_EVAL && !cmd_r && (rd_meta.used || !victim)) begin
      cur_r <= nxt_idx;
    end
  end

endmodule

/* src/nchance_clock_page_replacer.sv */
// ----------------------------------------------------------------------------
// nchance_clock_page_replacer
// Working-set table with n-chance clock page replacement.
// ----------------------------------------------------------------------------
// Usage: one in_ beat per command, one out_ beat per command, in order.
// A fault beat (command 0) places the page in the next free slot while the
// table is below its configured size, otherwise it starts a clock sweep that
// retires used bits and ages unused entries until one reaches the limit and
// is replaced. An access beat (command 1) marks a filled slot used, and
// modified on a write; an access to an unfilled slot is reported ignored.
// Placement and ignored accesses are answered from the SHORT state; a noted
// access and each entry a sweep visits go through READ and then EVAL. Every
// table visit is a read followed by a write-back on the single table RAM.
// Items are handled one at a time; in_ready is high whenever the sequencer
// is idle, including while a finished result waits in the output register.
// When the output register is full and out_ready is low, the sequencer
// holds its last step until the output register frees up.
// Reset clears the fill count, the clock hand and out_valid, leaves the
// sequencer idle and sets set_size to 16 and the sweep limit to 1.
// cfg_ writes take effect on the next cycle and belong to idle periods.
// ----------------------------------------------------------------------------
module nchance_clock_page_replacer import ncc_pkg::*; #(
  parameter int SET_DEPTH        = SET_DEPTH_DEF,
  parameter int PAGE_NUMBER_BITS = PAGE_NUMBER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [PAGE_W-1:0]       in_page,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic                    in_is_write,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_outcome,
  output logic [SLOT_W-1:0]       out_slot_res,
  output logic [PAGE_W-1:0]       out_victim_page,
  output logic                    out_victim_dirty
);

  localparam int IW = $clog2(SET_DEPTH);
  localparam int EW = PAGE_NUMBER_BITS + META_W;

  logic [SET_SIZE_W-1:0]    set_size_r;
  logic [SWEEP_LIMIT_W-1:0] sweep_limit_r;

  logic          mem_rd_en, mem_wr_en;
  logic [IW-1:0] mem_rd_addr, mem_wr_addr;
  logic [EW-1:0] mem_rd_data, mem_wr_data;

  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_r;
  result_t out_res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= SET_SIZE_RST;
      sweep_limit_r <= SWEEP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_SET_SIZE) begin
        set_size_r <= cfg_wdata[SET_SIZE_W-1:0];
      end else if (cfg_index == CFG_SWEEP_LIMIT) begin
        sweep_limit_r <= cfg_wdata[SWEEP_LIMIT_W-1:0];
      end
    end
  end

  // sequencer
  ncc_sweep_ctrl #(
    .SET_DEPTH        (SET_DEPTH),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_page     (in_page),
    .in_slot     (in_slot),
    .in_is_write (in_is_write),
    .set_size    (set_size_r),
    .sweep_limit (sweep_limit_r),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // table storage
  ncc_entry_ram #(
    .DEPTH (SET_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_res_r.outcome;
  assign out_slot_res     = out_res_r.slot;
  assign out_victim_page  = out_res_r.victim_page;
  assign out_victim_dirty = out_res_r.victim_dirty;

endmodule

/* tb/sv/nchance_clock_page_replacer_tb.sv */
// ----------------------------------------------------------------------------
// nchance_clock_page_replacer_tb
// Self-checking bench for the n-chance clock page replacer: a local model of
// the working-set table predicts every result beat, a monitor compares each
// out_ beat field by field, and directed, random and back-pressure traffic
// runs under several table sizes and sweep limits.
// ----------------------------------------------------------------------------
module nchance_clock_page_replacer_tb;
  import ncc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = SET_DEPTH_DEF;
  localparam logic CMD_FAULT  = 1'b0;
  localparam logic CMD_ACCESS = 1'b1;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic                  cfg_wr_en   = 1'b0;
  logic [0:0]            cfg_index   = CFG_SET_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  in_command  = CMD_FAULT;
  logic [PAGE_W-1:0]     in_page     = '0;
  logic [SLOT_W-1:0]     in_slot     = '0;
  logic                  in_is_write = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [1:0]            out_outcome;
  logic [SLOT_W-1:0]     out_slot_res;
  logic [PAGE_W-1:0]     out_victim_page;
  logic                  out_victim_dirty;

  nchance_clock_page_replacer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_page          (in_page),
    .in_slot          (in_slot),
    .in_is_write      (in_is_write),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_slot_res     (out_slot_res),
    .out_victim_page  (out_victim_page),
    .out_victim_dirty (out_victim_dirty)
  );

  // shadow copy of the working-set table and its registers
  logic [PAGE_W-1:0]        shadow_page  [TABLE_SLOTS];
  int                       shadow_age   [TABLE_SLOTS];
  bit                       shadow_used  [TABLE_SLOTS];
  bit                       shadow_dirty [TABLE_SLOTS];
  int                       shadow_fill  = 0;
  int                       shadow_hand  = 0;
  logic [SET_SIZE_W-1:0]    shadow_size  = SET_SIZE_RST;
  logic [SWEEP_LIMIT_W-1:0] shadow_limit = SWEEP_LIMIT_RST;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;

  // traffic shaping knobs
  bit sender_gaps    = 1'b0;
  bit receiver_stall = 1'b0;
  bit hold_pending   = 1'b0;
  int hold_left      = 0;

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_page[i]  = '0;
      shadow_age[i]   = 0;
      shadow_used[i]  = 1'b0;
      shadow_dirty[i] = 1'b0;
    end
  end

  // predict the result of one accepted beat and update the shadow table
  task automatic predict_page_event(input logic cmd, input logic [PAGE_W-1:0] pg,
                                    input logic [SLOT_W-1:0] sl, input logic wr,
                                    output result_t res);
    int  span;
    int  limit;
    int  reach;
    int  h;
    bit  neg;
    bit  found;
    res.outcome      = OC_NOTED;
    res.slot         = sl;
    res.victim_page  = '0;
    res.victim_dirty = 1'b0;
    if (cmd == CMD_ACCESS) begin
      if (int'(sl) < shadow_fill) begin
        shadow_used[sl] = 1'b1;
        if (wr) shadow_dirty[sl] = 1'b1;
      end else begin
        res.outcome = OC_IGNORED;
      end
      return;
    end
    span = int'(shadow_size);
    if (span == 0) span = 1;
    if (span > TABLE_SLOTS) span = TABLE_SLOTS;
    // free slot left: place without sweeping
    if (shadow_fill < span) begin
      h = shadow_fill;
      shadow_page[h]  = pg;
      shadow_age[h]   = 0;
      shadow_used[h]  = 1'b0;
      shadow_dirty[h] = 1'b0;
      shadow_fill     = h + 1;
      shadow_hand     = 0;
      res.outcome     = OC_PLACED;
      res.slot        = SLOT_W'(h);
      return;
    end
    // clock sweep over the filled slots until a victim is found
    neg   = shadow_limit[SWEEP_LIMIT_W-1];
    limit = neg ? (256 - int'(shadow_limit)) : int'(shadow_limit);
    h     = (shadow_hand >= shadow_fill) ? 0 : shadow_hand;
    found = 1'b0;
    while (!found) begin
      if (!shadow_used[h]) begin
        if (shadow_age[h] < 255) shadow_age[h]++;
        reach = limit + ((neg && shadow_dirty[h]) ? 1 : 0);
        if (shadow_age[h] >= reach) begin
          res.outcome      = OC_REPLACED;
          res.slot         = SLOT_W'(h);
          res.victim_page  = shadow_page[h];
          res.victim_dirty = shadow_dirty[h];
          shadow_page[h]   = pg;
          shadow_age[h]    = 0;
          shadow_used[h]   = 1'b1;
          shadow_dirty[h]  = 1'b0;
          shadow_hand      = (h + 1 >= shadow_fill) ? 0 : h + 1;
          found            = 1'b1;
        end
      end else begin
        shadow_used[h] = 1'b0;
        shadow_age[h]  = 0;
      end
      if (!found) h = (h + 1 >= shadow_fill) ? 0 : h + 1;
    end
  endtask

  // send one beat; called and returning at a falling edge, in_valid left high
  task automatic send_beat(input logic cmd, input logic [PAGE_W-1:0] pg,
                           input logic [SLOT_W-1:0] sl, input logic wr);
    result_t res;
    if (sender_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 35);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_page     <= pg;
    in_slot     <= sl;
    in_is_write <= wr;
    do @(posedge clk); while (!in_ready);
    predict_page_event(cmd, pg, sl, wr, res);
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  // random beat: mostly faults and accesses to filled slots, some stray accesses
  task automatic send_random_beat(input int fault_pct);
    logic              cmd;
    logic [SLOT_W-1:0] sl;
    cmd = ($urandom_range(99) < fault_pct) ? CMD_FAULT : CMD_ACCESS;
    if (shadow_fill > 0 && $urandom_range(9) < 8)
      sl = SLOT_W'($urandom_range(shadow_fill - 1));
    else
      sl = SLOT_W'($urandom);
    send_beat(cmd, PAGE_W'($urandom), sl, 1'($urandom));
  endtask

  // drop valid and wait until every predicted beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write both registers on consecutive cycles while the block is idle
  task automatic write_config(input logic [SET_SIZE_W-1:0] size,
                              input logic [SWEEP_LIMIT_W-1:0] sweeps);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SET_SIZE;
    cfg_wdata <= {3'($urandom), size};
    @(negedge clk);
    cfg_index <= CFG_SWEEP_LIMIT;
    cfg_wdata <= sweeps;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_size  = size;
    shadow_limit = sweeps;
    @(negedge clk);
  endtask

  // receiver: random stalls, steady ready, or a long counted hold-off
  initial begin : result_receiver
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (receiver_stall) begin
        out_ready <= ($urandom_range(99) >= 35);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing predicted: outcome %0d slot %0d",
               out_outcome, out_slot_res);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_outcome !== want.outcome) begin
          $error("outcome expected %0d got %0d", want.outcome, out_outcome);
          mismatch_count++;
        end
        if (out_slot_res !== want.slot) begin
          $error("slot_res expected %0d got %0d", want.slot, out_slot_res);
          mismatch_count++;
        end
        if (out_victim_page !== want.victim_page) begin
          $error("victim_page expected 0x%05h got 0x%05h",
                 want.victim_page, out_victim_page);
          mismatch_count++;
        end
        if (out_victim_dirty !== want.victim_dirty) begin
          $error("victim_dirty expected %0d got %0d",
                 want.victim_dirty, out_victim_dirty);
          mismatch_count++;
        end
      end
    end
  end

  // corner cases: tiny table, zero limit, full table, extreme limits
  task automatic test_directed_cases();
    write_config(5'd0, 8'd0);
    send_beat(CMD_ACCESS, PAGE_W'($urandom), 4'd0, 1'b1);
    send_beat(CMD_ACCESS, PAGE_W'($urandom), 4'd15, 1'b0);
    send_beat(CMD_FAULT, 20'h00000, SLOT_W'($urandom), 1'($urandom));
    send_beat(CMD_FAULT, 20'hFFFFF, SLOT_W'($urandom), 1'($urandom));
    send_beat(CMD_ACCESS, PAGE_W'($urandom), 4'd0, 1'b1);
    send_beat(CMD_FAULT, 20'h5A5A5, SLOT_W'($urandom), 1'($urandom));
    drain_results();
    // oversize request saturates to the whole table, most negative limit
    write_config(5'd31, 8'h80);
    for (int i = 1; i < TABLE_SLOTS; i++)
      send_beat(CMD_FAULT, PAGE_W'(20'hFFFFF ^ (i * 20'h11111)), SLOT_W'(i), 1'b0);
    send_beat(CMD_ACCESS, PAGE_W'($urandom), 4'd3, 1'b1);
    send_beat(CMD_ACCESS, PAGE_W'($urandom), 4'd15, 1'b0);
    send_beat(CMD_FAULT, PAGE_W'($urandom), SLOT_W'($urandom), 1'b1);
    drain_results();
    write_config(5'd17, 8'd127);
    send_beat(CMD_FAULT, PAGE_W'($urandom), SLOT_W'($urandom), 1'b0);
    drain_results();
    // size dropped below the fill level: faults keep replacing
    write_config(5'd1, 8'h81);
    send_beat(CMD_FAULT, PAGE_W'($urandom), SLOT_W'($urandom), 1'b1);
    send_beat(CMD_ACCESS, PAGE_W'($urandom), 4'd5, 1'b1);
    drain_results();
  endtask

  // random phases, each with its own size, limit and idling pattern
  task automatic test_random_traffic();
    logic [SET_SIZE_W-1:0]    size;
    logic [SWEEP_LIMIT_W-1:0] sweeps;
    int                       fault_pct;
    for (int phase = 0; phase < 16; phase++) begin
      if ($urandom_range(2) == 0) size = SET_SIZE_W'($urandom_range(6, 1));
      else                        size = SET_SIZE_W'($urandom_range(31));
      if (phase % 8 == 7) sweeps = SWEEP_LIMIT_W'($urandom_range(255));
      else                sweeps = SWEEP_LIMIT_W'($urandom_range(6)) - 8'd3;
      write_config(size, sweeps);
      // the first two phases run with no idling at all
      sender_gaps    = (phase >= 2);
      receiver_stall = (phase >= 2);
      fault_pct      = $urandom_range(60, 20);
      repeat (110) send_random_beat(fault_pct);
      drain_results();
    end
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_output_backpressure();
    write_config(5'd16, 8'd2);
    sender_gaps    = 1'b0;
    receiver_stall = 1'b0;
    hold_pending   = 1'b1;
    repeat (150) send_random_beat(40);
    drain_results();
  endtask

  initial begin : test_sequence
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_random_traffic();
    test_output_backpressure();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin : run_limit
    #150_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
src/ncc_pkg.sv
src/ncc_entry_ram.sv
src/ncc_sweep_ctrl.sv
src/nchance_clock_page_replacer.sv
tb/sv/nchance_clock_page_replacer_tb.sv
